// ===== rtl/git_shell_command_repo_extractor_macros.svh =====
// Assertion macros shared by the extractor RTL.
// Depends on nothing; files that check their logic include it by name.
`ifndef GIT_SHELL_COMMAND_REPO_EXTRACTOR_MACROS_SVH
`define GIT_SHELL_COMMAND_REPO_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define GSCRE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GSCRE_ASSERT(lbl, prop, msg) `GSCRE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define GSCRE_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define GSCRE_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== rtl/gscre_pkg.sv =====
// Package for the git shell command repository extractor.
// Types, codes and command word tables; used by the datapath, sequencer and top module.
`timescale 1ns / 1ps
package gscre_pkg;

  localparam int unsigned SEGMENT_MAX = 63;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_BANG   = 8'h21;
  localparam logic [7:0] CHAR_QUOTE  = 8'h27;
  localparam logic [7:0] CHAR_SLASH  = 8'h2f;
  localparam logic [7:0] CHAR_BSLASH = 8'h5c;

  localparam logic [4:0] WORD_A_LEN = 5'd16;
  localparam logic [4:0] WORD_B_LEN = 5'd15;
  localparam logic [4:0] WORD_C_LEN = 5'd18;
  localparam logic [4:0] POS_MAX    = 5'd31;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [2:0] {
    MODE_WORD,
    MODE_REPO,
    MODE_QSTART,
    MODE_QUOTED,
    MODE_ESCAPE
  } parse_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND,
    ST_FINAL
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_command;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic push_byte;
    logic push_final;
  } ctrl_cmd_t;

  typedef struct packed {
    logic drain_start;
    logic end_in;
    logic last_byte;
    logic end_pending;
    logic out_room;
  } dp_status_t;

  // git-receive-pack
  function automatic logic [7:0] word_a_char(logic [4:0] idx);
    logic [7:0] ch;
    unique case (idx)
      5'd0:  ch = "g";
      5'd1:  ch = "i";
      5'd2:  ch = "t";
      5'd3:  ch = "-";
      5'd4:  ch = "r";
      5'd5:  ch = "e";
      5'd6:  ch = "c";
      5'd7:  ch = "e";
      5'd8:  ch = "i";
      5'd9:  ch = "v";
      5'd10: ch = "e";
      5'd11: ch = "-";
      5'd12: ch = "p";
      5'd13: ch = "a";
      5'd14: ch = "c";
      5'd15: ch = "k";
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  // git-upload-pack
  function automatic logic [7:0] word_b_char(logic [4:0] idx);
    logic [7:0] ch;
    unique case (idx)
      5'd0:  ch = "g";
      5'd1:  ch = "i";
      5'd2:  ch = "t";
      5'd3:  ch = "-";
      5'd4:  ch = "u";
      5'd5:  ch = "p";
      5'd6:  ch = "l";
      5'd7:  ch = "o";
      5'd8:  ch = "a";
      5'd9:  ch = "d";
      5'd10: ch = "-";
      5'd11: ch = "p";
      5'd12: ch = "a";
      5'd13: ch = "c";
      5'd14: ch = "k";
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  // git-upload-archive
  function automatic logic [7:0] word_c_char(logic [4:0] idx);
    logic [7:0] ch;
    unique case (idx)
      5'd0:  ch = "g";
      5'd1:  ch = "i";
      5'd2:  ch = "t";
      5'd3:  ch = "-";
      5'd4:  ch = "u";
      5'd5:  ch = "p";
      5'd6:  ch = "l";
      5'd7:  ch = "o";
      5'd8:  ch = "a";
      5'd9:  ch = "d";
      5'd10: ch = "-";
      5'd11: ch = "a";
      5'd12: ch = "r";
      5'd13: ch = "c";
      5'd14: ch = "h";
      5'd15: ch = "i";
      5'd16: ch = "v";
      5'd17: ch = "e";
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/gscre_dp.sv =====
// Datapath of the extractor: parser state, segment buffer, output register.
// Depends on gscre_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "git_shell_command_repo_extractor_macros.svh"
module gscre_dp #(
  parameter int unsigned SegmentMax = gscre_pkg::SEGMENT_MAX
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gscre_pkg::in_item_t    in_i,
  input  gscre_pkg::ctrl_cmd_t   cmd_i,
  output gscre_pkg::dp_status_t  status_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output gscre_pkg::out_item_t   out_o
);
  import gscre_pkg::*;

  localparam int unsigned LenW  = $clog2(SegmentMax + 1);
  localparam int unsigned AddrW = (SegmentMax > 1) ? $clog2(SegmentMax) : 1;

  parse_mode_e      mode_q, mode_d;
  logic [4:0]       pos_q, pos_d;
  logic [2:0]       match_q, match_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             emitted_q, emitted_d;
  logic             err_q, err_d;
  logic             nul_q, nul_d;
  logic [LenW-1:0]  drain_q, drain_d;
  logic [LenW-1:0]  rd_idx_q;
  logic             end_pend_q;
  logic             fin_ok_q, fin_ok_d;
  logic             out_valid_q;
  out_item_t        out_q;
  logic [7:0]       rd_data_q;
  logic [7:0]       mem [SegmentMax];

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       ch;
  logic             last_byte;

  assign ch = in_i.char_in;

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    match_d   = match_q;
    len_d     = len_q;
    emitted_d = emitted_q;
    err_d     = err_q;
    nul_d     = nul_q;
    drain_d   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    if (!nul_q && !err_q) begin
      if (ch == CHAR_NUL) begin
        nul_d = 1'b1;
      end else begin
        unique case (mode_q)
          MODE_WORD: begin
            if (ch == CHAR_SPACE) begin
              if ((match_q[0] && pos_q == WORD_A_LEN) ||
                  (match_q[1] && pos_q == WORD_B_LEN) ||
                  (match_q[2] && pos_q == WORD_C_LEN)) begin
                mode_d = MODE_REPO;
              end else begin
                err_d = 1'b1;
              end
            end else begin
              if (!(pos_q < WORD_A_LEN && word_a_char(pos_q) == ch)) match_d[0] = 1'b0;
              if (!(pos_q < WORD_B_LEN && word_b_char(pos_q) == ch)) match_d[1] = 1'b0;
              if (!(pos_q < WORD_C_LEN && word_c_char(pos_q) == ch)) match_d[2] = 1'b0;
              if (pos_q < POS_MAX) pos_d = pos_q + 5'd1;
            end
          end
          MODE_REPO: begin
            if (ch == CHAR_QUOTE) begin
              mode_d = MODE_QSTART;
            end else if (ch == CHAR_BSLASH) begin
              mode_d = MODE_ESCAPE;
            end else begin
              err_d = 1'b1;
            end
          end
          MODE_QSTART: begin
            if (ch == CHAR_QUOTE) begin
              mode_d = MODE_REPO;
            end else begin
              // drop a leading slash while nothing has gone out yet
              len_d = '0;
              if (emitted_q || ch != CHAR_SLASH) begin
                wr_en = 1'b1;
                len_d = LenW'(1);
              end
              mode_d = MODE_QUOTED;
            end
          end
          MODE_QUOTED: begin
            if (ch == CHAR_QUOTE) begin
              drain_d = len_q;
              if (len_q != '0) emitted_d = 1'b1;
              len_d  = '0;
              mode_d = MODE_REPO;
            end else if (len_q >= LenW'(SegmentMax)) begin
              err_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = len_q[AddrW-1:0];
              len_d   = len_q + LenW'(1);
            end
          end
          MODE_ESCAPE: begin
            if (ch == CHAR_BANG || ch == CHAR_QUOTE) begin
              // no segment is open here: park the byte in entry zero, drain one
              wr_en     = 1'b1;
              drain_d   = LenW'(1);
              emitted_d = 1'b1;
              mode_d    = MODE_REPO;
            end else begin
              err_d = 1'b1;
            end
          end
          default: begin
            err_d = 1'b1;
          end
        endcase
      end
    end
    fin_ok_d = emitted_d && !err_d;
    if (in_i.end_of_command) begin
      mode_d    = MODE_WORD;
      pos_d     = '0;
      match_d   = 3'b111;
      len_d     = '0;
      emitted_d = 1'b0;
      err_d     = 1'b0;
      nul_d     = 1'b0;
    end
  end

  assign last_byte = (rd_idx_q + LenW'(1)) == drain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_WORD;
      pos_q       <= '0;
      match_q     <= 3'b111;
      len_q       <= '0;
      emitted_q   <= 1'b0;
      err_q       <= 1'b0;
      nul_q       <= 1'b0;
      drain_q     <= '0;
      rd_idx_q    <= '0;
      end_pend_q  <= 1'b0;
      fin_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        mode_q     <= mode_d;
        pos_q      <= pos_d;
        match_q    <= match_d;
        len_q      <= len_d;
        emitted_q  <= emitted_d;
        err_q      <= err_d;
        nul_q      <= nul_d;
        drain_q    <= drain_d;
        rd_idx_q   <= '0;
        end_pend_q <= in_i.end_of_command;
        fin_ok_q   <= fin_ok_d;
      end else if (cmd_i.push_byte) begin
        rd_idx_q <= rd_idx_q + LenW'(1);
      end
      if (cmd_i.push_byte || cmd_i.push_final) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      mem[wr_addr] <= ch;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_byte) begin
      out_q.kind     <= KIND_BYTE;
      out_q.out_byte <= rd_data_q;
      out_q.last     <= last_byte && !end_pend_q;
    end else if (cmd_i.push_final) begin
      out_q.kind     <= fin_ok_q ? KIND_OK : KIND_ERR;
      out_q.out_byte <= 8'h00;
      out_q.last     <= 1'b1;
    end
  end

  assign status_o.drain_start = drain_d != '0;
  assign status_o.end_in      = in_i.end_of_command;
  assign status_o.last_byte   = last_byte;
  assign status_o.end_pending = end_pend_q;
  assign status_o.out_room    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `GSCRE_ASSERT(a_len_bound, len_q <= LenW'(SegmentMax), "segment length past buffer size")
  `GSCRE_ASSERT(a_read_in_range, cmd_i.rd_issue |-> rd_idx_q < drain_q, "read beyond drained run")
  `GSCRE_ASSERT(a_valid_from_push, $rose(out_valid_q) |-> $past(cmd_i.push_byte || cmd_i.push_final), "output valid without a push")
endmodule

// ===== rtl/gscre_ctrl.sv =====
// Sequencer of the extractor: accepts bytes and steps the drain and status output.
// Depends on gscre_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "git_shell_command_repo_extractor_macros.svh"
module gscre_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gscre_pkg::dp_status_t status_i,
  output gscre_pkg::ctrl_cmd_t  cmd_o
);
  import gscre_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.drain_start) begin
            state_d = ST_READ;
          end else if (status_i.end_in) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_READ: state_d = ST_SEND;
      ST_SEND: begin
        if (status_i.out_room) begin
          if (!status_i.last_byte) begin
            state_d = ST_READ;
          end else if (status_i.end_pending) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        if (status_i.out_room) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ:  cmd_o.rd_issue   = 1'b1;
      ST_SEND:  cmd_o.push_byte  = status_i.out_room;
      ST_FINAL: cmd_o.push_final = status_i.out_room;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `GSCRE_ASSERT(a_one_push, !(cmd_o.push_byte && cmd_o.push_final), "byte and status pushed together")
  `GSCRE_ASSERT(a_send_after_read, state_q == ST_SEND |-> $past(state_q) == ST_READ || $past(state_q) == ST_SEND, "send without a read")
  `GSCRE_ASSERT(a_final_done, (state_q == ST_FINAL && status_i.out_room) |=> state_q == ST_IDLE, "status transfer did not return to idle")
endmodule

// ===== rtl/git_shell_command_repo_extractor.sv =====
// Flow: a closing quote with N buffered bytes gives N results, each read from the segment
// buffer and then put in the output register, then the status if the byte ends the command.
// Throughput: one byte per cycle while bytes cause no results; the next byte waits until all
// results of the current one sit in the output register, which hides one stalled transfer.
// Reset: rst_ni is asynchronous, active low, and returns the parser to the command word.
`timescale 1ns / 1ps
module git_shell_command_repo_extractor #(
  parameter int unsigned SegmentMax = gscre_pkg::SEGMENT_MAX
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gscre_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gscre_pkg::out_item_t out_o
);
  import gscre_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  gscre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gscre_dp #(
    .SegmentMax (SegmentMax)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );
endmodule

// ===== verif/git_shell_command_repo_extractor_tb.sv =====
// Self-checking testbench for the git shell command repository extractor.
// Drives shell commands byte by byte, predicts the extracted path and status in a
// local parser model; depends on gscre_pkg and git_shell_command_repo_extractor.
`timescale 1ns / 1ps
module git_shell_command_repo_extractor_tb;
  import gscre_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_GAP        = 40;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  git_shell_command_repo_extractor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #2 clk_i = ~clk_i;

  string cmd_words [3] = '{"git-receive-pack", "git-upload-pack", "git-upload-archive"};

  // Parser model state
  parse_mode_e cur_mode;
  logic [4:0]  word_pos;
  logic [2:0]  word_hits;
  logic [7:0]  seg_buf [SEGMENT_MAX];
  logic [5:0]  seg_cnt;
  logic        any_out;
  logic        err_latched;
  logic        nul_hit;

  out_item_t   extracted_q [$];
  logic [7:0]  cmd_buf [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int idle_cycles    = 0;
  int n_fail         = 0;

  task automatic clear_parser();
    cur_mode    = MODE_WORD;
    word_pos    = '0;
    word_hits   = 3'b111;
    seg_cnt     = '0;
    any_out     = 1'b0;
    err_latched = 1'b0;
    nul_hit     = 1'b0;
  endtask

  function automatic out_item_t make_result(logic [1:0] kind, logic [7:0] b);
    out_item_t r;
    r.kind     = kind;
    r.out_byte = b;
    r.last     = 1'b0;
    return r;
  endfunction

  task automatic buffer_char(input logic [7:0] c);
    if (seg_cnt >= SEGMENT_MAX) begin
      err_latched = 1'b1;
    end else begin
      seg_buf[seg_cnt] = c;
      seg_cnt++;
    end
  endtask

  // Predict every result caused by one accepted byte
  task automatic extractor_step(input in_item_t it);
    out_item_t  res_q [$];
    out_item_t  r;
    logic [7:0] c;
    logic       hit;
    c = it.char_in;
    if (!nul_hit && !err_latched) begin
      if (c == CHAR_NUL) begin
        nul_hit = 1'b1;
      end else begin
        case (cur_mode)
          MODE_WORD: begin
            if (c == CHAR_SPACE) begin
              hit = 1'b0;
              for (int k = 0; k < 3; k++)
                if (word_hits[k] && word_pos == cmd_words[k].len()) hit = 1'b1;
              if (hit) cur_mode = MODE_REPO;
              else err_latched = 1'b1;
            end else begin
              for (int k = 0; k < 3; k++)
                if (!(word_pos < cmd_words[k].len() && cmd_words[k][word_pos] == c))
                  word_hits[k] = 1'b0;
              if (word_pos != POS_MAX) word_pos++;
            end
          end
          MODE_REPO: begin
            if (c == CHAR_QUOTE) cur_mode = MODE_QSTART;
            else if (c == CHAR_BSLASH) cur_mode = MODE_ESCAPE;
            else err_latched = 1'b1;
          end
          MODE_QSTART: begin
            if (c == CHAR_QUOTE) begin
              cur_mode = MODE_REPO;
            end else begin
              seg_cnt = '0;
              // drop a leading slash until the path has started
              if (any_out || c != CHAR_SLASH) buffer_char(c);
              cur_mode = MODE_QUOTED;
            end
          end
          MODE_QUOTED: begin
            if (c == CHAR_QUOTE) begin
              for (int i = 0; i < seg_cnt; i++)
                res_q.push_back(make_result(KIND_BYTE, seg_buf[i]));
              if (seg_cnt != 0) any_out = 1'b1;
              seg_cnt  = '0;
              cur_mode = MODE_REPO;
            end else begin
              buffer_char(c);
            end
          end
          MODE_ESCAPE: begin
            if (c == CHAR_BANG || c == CHAR_QUOTE) begin
              res_q.push_back(make_result(KIND_BYTE, c));
              any_out  = 1'b1;
              cur_mode = MODE_REPO;
            end else begin
              err_latched = 1'b1;
            end
          end
          default: err_latched = 1'b1;
        endcase
      end
    end
    if (it.end_of_command) begin
      res_q.push_back(make_result((any_out && !err_latched) ? KIND_OK : KIND_ERR, 8'h00));
      clear_parser();
    end
    if (res_q.size() != 0) begin
      r = res_q[res_q.size() - 1];
      r.last = 1'b1;
      res_q[res_q.size() - 1] = r;
    end
    foreach (res_q[i]) extracted_q.push_back(res_q[i]);
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic eoc);
    in_item_t it;
    int       gap;
    it.char_in        = ch;
    it.end_of_command = eoc;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    extractor_step(it);
  endtask

  task automatic send_command();
    foreach (cmd_buf[i]) send_byte(cmd_buf[i], i == cmd_buf.size() - 1);
    cmd_buf.delete();
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (extracted_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CHAR_QUOTE);
    return c;
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) cmd_buf.push_back(s[i]);
  endtask

  task automatic add_segment(input int n, input bit slash);
    cmd_buf.push_back(CHAR_QUOTE);
    if (slash) cmd_buf.push_back(CHAR_SLASH);
    repeat (n) cmd_buf.push_back(rand_char());
    cmd_buf.push_back(CHAR_QUOTE);
  endtask

  task automatic add_escape();
    cmd_buf.push_back(CHAR_BSLASH);
    cmd_buf.push_back($urandom_range(1) ? CHAR_BANG : CHAR_QUOTE);
  endtask

  task automatic build_random_command();
    int sel;
    int n;
    cmd_buf.delete();
    sel = $urandom_range(99);
    if (sel < 12) begin
      n = $urandom_range(1, 12);
      repeat (n) cmd_buf.push_back(8'($urandom_range(255)));
    end else begin
      add_str(cmd_words[$urandom_range(2)]);
      cmd_buf.push_back(CHAR_SPACE);
      repeat ($urandom_range(1, 4)) begin
        n = $urandom_range(99);
        if (n < 15) add_segment(0, 1'b0);
        else if (n < 40) add_escape();
        else if (n < 43) add_segment($urandom_range(40, 64), $urandom_range(3) == 0);
        else add_segment($urandom_range(1, 8), $urandom_range(3) == 0);
      end
      // break a share of the commands: a stray byte anywhere, or a missing last byte
      if ($urandom_range(99) < 20)
        cmd_buf[$urandom_range(cmd_buf.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(99) < 8) void'(cmd_buf.pop_back());
    end
  endtask

  task automatic test_command_words();
    add_str("git-receive-pack \\!'/x'");     send_command();
    add_str("git-upload-pack '''/r'\\'");    send_command();
    add_str("git-upload-archive 'a'");       send_command();
  endtask

  task automatic test_rejected_words();
    add_str("git-upload ");                  send_command();
    add_str("git-receive-pac ");             send_command();
    cmd_buf.push_back(8'hFF);                send_command();
    cmd_buf.push_back(CHAR_SPACE);           send_command();
  endtask

  task automatic test_repo_quoting();
    add_str("git-upload-pack \\!'ab");       send_command();
    add_str("git-upload-pack x");            send_command();
    add_str("git-upload-pack \\a");          send_command();
    add_str("git-upload-pack 'a'");
    cmd_buf.push_back(CHAR_NUL);
    add_str("'b'");                          send_command();
    cmd_buf.push_back(CHAR_NUL);
    add_str("ab");                           send_command();
  endtask

  task automatic test_segment_limits();
    // fullest segment behind a dropped slash, then one byte too many
    add_str("git-upload-archive '/");
    cmd_buf.push_back(8'hFF);
    cmd_buf.push_back(8'h01);
    repeat (SEGMENT_MAX - 2) cmd_buf.push_back(rand_char());
    cmd_buf.push_back(CHAR_QUOTE);
    send_command();
    add_str("git-upload-pack '");
    repeat (SEGMENT_MAX + 1) cmd_buf.push_back(rand_char());
    send_command();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    add_str(cmd_words[$urandom_range(2)]);
    cmd_buf.push_back(CHAR_SPACE);
    add_segment(4, 1'b0);
    add_escape();
    add_segment(3, 1'b1);
    send_command();
  endtask

  task automatic test_random(input int n_bytes, input int s_pct, input int r_pct);
    int sent;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_command();
      sent += cmd_buf.size();
      send_command();
    end
  endtask

  // Result checker and receiver side
  always @(posedge clk_i) begin : chk
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (extracted_q.size() == 0) begin
        $error("unexpected result: kind %0d out_byte %02h last %0d",
               out_o.kind, out_o.out_byte, out_o.last);
        n_fail++;
      end else begin
        want = extracted_q.pop_front();
        if (out_o.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_o.kind);
          n_fail++;
        end
        if (out_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_o.out_byte);
          n_fail++;
        end
        if (out_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_o.last);
          n_fail++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("git_shell_command_repo_extractor_tb: errors");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_command_words();
    pause_until_drained();
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    test_rejected_words();
    pause_until_drained();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    test_repo_quoting();
    pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    test_segment_limits();
    pause_until_drained();
    test_random(1, 28, 28);
    pause_until_drained();
    test_output_backpressure();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (extracted_q.size() != 0) begin
      $error("%0d expected results never arrived", extracted_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("git_shell_command_repo_extractor_tb: clean");
    end else begin
      $display("git_shell_command_repo_extractor_tb: errors");
    end
    $finish;
  end

endmodule
